>>> rtl/nwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwd_pkg
// Types and header field positions shared by the notification word deframer.
// ----------------------------------------------------------------------------
package nwd_pkg;

   localparam int unsigned WordWidth     = 32;
   localparam int unsigned SeqWidth      = 16;
   localparam int unsigned BlenWidth     = 4;
   localparam int unsigned EventWidth    = 6;
   localparam int unsigned RemainWidth   = 5;

   // header layout
   localparam int unsigned SeqLsb        = 16;
   localparam int unsigned BlenLsb       = 12;
   localparam int unsigned EventLsb      = 0;

   localparam int unsigned RspDataWidth  = 48;

   typedef struct packed {
      logic [SeqWidth-1:0]    expected_sequence;
      logic [RemainWidth-1:0] payload_remaining;
      logic [EventWidth-1:0]  record_event;
      logic                   record_deliverable;
   } nwd_state_type;

   typedef struct packed {
      logic                   truncated;
      logic                   bad_event;
      logic                   sequence_error;
      logic [WordWidth-1:0]   event_value;
      logic [EventWidth-1:0]  event_number;
      logic                   deliver;
   } nwd_result_type;

endpackage

>>> rtl/notification_word_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// notification_word_deframer
// Walks packets of 32-bit notification words and reports one result word per
// input word: delivered event values and sequence, event and truncation flags.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one notification word per handshake in req_tdata, req_tlast on
//            the final word of a packet.
//   rsp_*  : exactly one result word per accepted request word, in order.
//   Path: a word accepted on req_* passes the input register, the decode
//            step and the result register before it shows on rsp_tvalid.
//   Throughput: one word per cycle while rsp_tready is high, set by
//            the single decode step between the input and result registers.
//   Stall: while rsp_tready is low the result register holds; the input
//            register still takes one more word, then req_tready drops.
//   Reset: synchronous, active high; empties both registers, clears the
//            expected sequence and returns the deframer to expecting a header.
// ----------------------------------------------------------------------------
module notification_word_deframer #(
   parameter int unsigned EVENT_COUNT = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [nwd_pkg::WordWidth-1:0]        req_tdata,  // [31:0] word
   input  logic                                 req_tlast,  // last_word
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] deliver, [6:1] event_number, [38:7] event_value,
   // [39] sequence_error, [40] bad_event, [41] truncated, [47:42] zero
   output logic [nwd_pkg::RspDataWidth-1:0]     rsp_tdata
);
   import nwd_pkg::*;

   localparam int unsigned ResultWidth = $bits(nwd_result_type);

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [WordWidth-1:0] in_word_ff,  in_word_in;
   logic                 in_last_ff,  in_last_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   nwd_result_type       rsp_data_ff,  rsp_data_in;

   // deframer state
   nwd_state_type        state_ff, state_in;

   nwd_result_type       step_result;
   nwd_state_type        step_state;

   logic                 advance;
   logic                 take_req;

   // move a word from the input register into the result register
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   // take a new word when the input register is empty or emptying
   assign req_tready = !in_valid_ff || advance;
   assign take_req   = req_tvalid && req_tready;

   nwd_step #(
      .EVENT_COUNT (EVENT_COUNT)
   ) u_step (
      .state_cur (state_ff),
      .word      (in_word_ff),
      .last_word (in_last_ff),
      .result    (step_result),
      .state_nxt (step_state)
   );

   always_comb begin
      // input register: load on accept, empty when the word advances
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      in_last_in  = in_last_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
         in_word_in  = req_tdata;
         in_last_in  = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      // result register: drop a taken result, load the decoded one
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end

      // advance state only with the word that produced it
      state_in = advance ? step_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      in_last_ff  <= in_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RspDataWidth-ResultWidth)'(0), rsp_data_ff};

`ifndef SYNTH
   // a delivery only happens on a payload word, never with header flags
   a_deliver_on_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.deliver
         |-> !rsp_data_ff.sequence_error && !rsp_data_ff.bad_event)
      else $error("delivery carries header flags");

   // completing a record and cutting one off cannot coincide
   a_deliver_not_trunc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.deliver && rsp_data_ff.truncated))
      else $error("delivery flagged as truncated");

   // the end of a packet always returns to expecting a header
   a_last_resets_count: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff.payload_remaining == '0)
      else $error("payload count survives end of packet");

   // a record never holds more than sixteen payload words
   a_remaining_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.payload_remaining <= RemainWidth'(16))
      else $error("payload count out of range");

   // a stalled result is never overwritten
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled result overwritten");
`endif

endmodule

>>> rtl/nwd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwd_step
// Per-word decode: header check or payload count, result and next state.
// ----------------------------------------------------------------------------
module nwd_step #(
   parameter int unsigned EVENT_COUNT = 32
) (
   input  nwd_pkg::nwd_state_type              state_cur,
   input  logic [nwd_pkg::WordWidth-1:0]       word,
   input  logic                                last_word,
   output nwd_pkg::nwd_result_type             result,
   output nwd_pkg::nwd_state_type              state_nxt
);
   import nwd_pkg::*;

   localparam logic [EventWidth:0] EventLimit = (EventWidth+1)'(EVENT_COUNT);

   logic [SeqWidth-1:0]   hdr_seq;
   logic [BlenWidth-1:0]  hdr_blen;
   logic [EventWidth-1:0] hdr_event;
   logic                  is_header;
   logic                  hdr_bad;
   logic                  rec_valid;

   assign hdr_seq   = word[SeqLsb +: SeqWidth];
   assign hdr_blen  = word[BlenLsb +: BlenWidth];
   assign hdr_event = word[EventLsb +: EventWidth];
   assign is_header = (state_cur.payload_remaining == '0);
   assign hdr_bad   = !({1'b0, hdr_event} < EventLimit);
   assign rec_valid = ({1'b0, state_cur.record_event} < EventLimit);

   always_comb begin
      result    = '0;
      state_nxt = state_cur;
      if (is_header) begin
         result.sequence_error        = (hdr_seq != state_cur.expected_sequence);
         result.bad_event             = hdr_bad;
         result.truncated             = last_word && !hdr_bad;
         state_nxt.expected_sequence  = hdr_seq + SeqWidth'(1);
         state_nxt.record_event       = hdr_event;
         state_nxt.record_deliverable = !hdr_bad && (hdr_blen == '0);
         state_nxt.payload_remaining  = RemainWidth'(hdr_blen) + RemainWidth'(1);
      end else begin
         if (state_cur.payload_remaining == RemainWidth'(1)) begin
            if (state_cur.record_deliverable) begin
               result.deliver      = 1'b1;
               result.event_number = state_cur.record_event;
               result.event_value  = word;
            end
         end else begin
            result.truncated = last_word && rec_valid;
         end
         state_nxt.payload_remaining = state_cur.payload_remaining - RemainWidth'(1);
      end
      // end of packet: drop any unread payload
      if (last_word) begin
         state_nxt.payload_remaining = '0;
      end
   end

endmodule
